@@ src/kpq_pkg.sv @@
// Shared types, constants and the key code table for the key press qualifier.
package kpq_pkg;

   localparam int KEY_COUNT_DEFAULT = 7;
   localparam int KEY_CODE_W        = 8;
   localparam int KEY_IDX_W         = 3;
   localparam int COUNT_W           = 8;
   localparam int MASK_W            = 7;
   localparam int CSR_INDEX_W       = 3;
   localparam int CSR_DATA_W        = 8;

   localparam logic [KEY_IDX_W-1:0] NO_KEY_INDEX = 3'd7;

   typedef enum logic [1:0] {
      MODE_SHORT  = 2'd0,
      MODE_REPEAT = 2'd1,
      MODE_LONG   = 2'd2,
      MODE_NONE   = 2'd3
   } qual_mode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_QUAL_MODE    = 3'd0,
      CSR_DEBOUNCE     = 3'd1,
      CSR_REPEAT_DELAY = 3'd2,
      CSR_LONG_PRESS   = 3'd3,
      CSR_REPEAT_MASK  = 3'd4,
      CSR_LONG_MASK    = 3'd5
   } csr_index_type;

   localparam qual_mode_type      RST_QUAL_MODE    = MODE_LONG;
   localparam logic [COUNT_W-1:0] RST_DEBOUNCE     = 8'd4;
   localparam logic [COUNT_W-1:0] RST_REPEAT_DELAY = 8'd40;
   localparam logic [COUNT_W-1:0] RST_LONG_PRESS   = 8'd80;
   localparam logic [MASK_W-1:0]  RST_REPEAT_MASK  = 7'd15;
   localparam logic [MASK_W-1:0]  RST_LONG_MASK    = 7'd32;

   // Active-low codes of keys 0..6
   localparam logic [KEY_CODE_W-1:0] KEY_CODES [7] = '{
      8'hFE, 8'hFD, 8'hFB, 8'hF7, 8'hEF, 8'hDF, 8'hBF
   };

   typedef struct packed {
      qual_mode_type       qual_mode;
      logic [COUNT_W-1:0]  debounce_count;
      logic [COUNT_W-1:0]  repeat_delay_count;
      logic [COUNT_W-1:0]  long_press_count;
      logic [MASK_W-1:0]   repeat_key_mask;
      logic [MASK_W-1:0]   long_key_mask;
   } kpq_cfg_type;

   typedef struct packed {
      logic                 no_key;
      logic                 found;
      logic [KEY_IDX_W-1:0] key_idx;
   } kpq_scan_type;

   typedef struct packed {
      logic                 key_event;
      logic [KEY_IDX_W-1:0] event_key;
      logic                 long_mark;
      logic                 key_held;
   } kpq_result_type;

endpackage

@@ src/kpq_decode.sv @@
// Key code matcher: raw active-low code to key index.
module kpq_decode #(
   parameter int KEY_COUNT = kpq_pkg::KEY_COUNT_DEFAULT
) (
   input  logic [kpq_pkg::KEY_CODE_W-1:0] raw_code,
   output logic                           found,
   output logic [kpq_pkg::KEY_IDX_W-1:0]  key_idx
);
   import kpq_pkg::*;

   always_comb begin
      found   = 1'b0;
      key_idx = NO_KEY_INDEX;
      for (int i = KEY_COUNT - 1; i >= 0; i--) begin
         if (raw_code == KEY_CODES[i]) begin
            found   = 1'b1;
            key_idx = KEY_IDX_W'(i);
         end
      end
   end

endmodule

@@ src/kpq_csr.sv @@
// Configuration registers of the key press qualifier.
module kpq_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_en,
   input  logic [kpq_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [kpq_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output kpq_pkg::kpq_cfg_type            cfg
);
   import kpq_pkg::*;

   kpq_cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_QUAL_MODE:    cfg_in.qual_mode          = qual_mode_type'(csr_wdata[1:0]);
            CSR_DEBOUNCE:     cfg_in.debounce_count     = csr_wdata;
            CSR_REPEAT_DELAY: cfg_in.repeat_delay_count = csr_wdata;
            CSR_LONG_PRESS:   cfg_in.long_press_count   = csr_wdata;
            CSR_REPEAT_MASK:  cfg_in.repeat_key_mask    = csr_wdata[MASK_W-1:0];
            CSR_LONG_MASK:    cfg_in.long_key_mask      = csr_wdata[MASK_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.qual_mode          <= RST_QUAL_MODE;
         cfg_ff.debounce_count     <= RST_DEBOUNCE;
         cfg_ff.repeat_delay_count <= RST_REPEAT_DELAY;
         cfg_ff.long_press_count   <= RST_LONG_PRESS;
         cfg_ff.repeat_key_mask    <= RST_REPEAT_MASK;
         cfg_ff.long_key_mask      <= RST_LONG_MASK;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ src/kpq_core.sv @@
// Hold counter, event rules and reported key state, one scan transaction per step.
module kpq_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  kpq_pkg::kpq_scan_type   scan,
   input  kpq_pkg::kpq_cfg_type    cfg,
   output kpq_pkg::kpq_result_type result
);
   import kpq_pkg::*;

   logic [KEY_IDX_W-1:0] tracked_key_ff, tracked_key_in;
   logic [COUNT_W-1:0]   hold_count_ff, hold_count_in;
   logic [COUNT_W-1:0]   threshold_ff, threshold_in;
   logic                 long_armed_ff, long_armed_in;
   logic                 repeat_started_ff, repeat_started_in;
   logic [KEY_IDX_W-1:0] reported_key_ff, reported_key_in;
   logic                 reported_long_ff, reported_long_in;
   logic                 event_flag;
   logic                 held;
   logic [COUNT_W-1:0]   count_next;
   logic [MASK_W:0]      repeat_mask_ext;
   logic [MASK_W:0]      long_mask_ext;

   assign repeat_mask_ext = {1'b0, cfg.repeat_key_mask};
   assign long_mask_ext   = {1'b0, cfg.long_key_mask};
   assign count_next = (scan.key_idx != tracked_key_ff) ? '0 : hold_count_ff + 1'b1;

   always_comb begin
      tracked_key_in    = tracked_key_ff;
      hold_count_in     = hold_count_ff;
      threshold_in      = threshold_ff;
      long_armed_in     = long_armed_ff;
      repeat_started_in = repeat_started_ff;
      reported_key_in   = reported_key_ff;
      reported_long_in  = reported_long_ff;
      event_flag        = 1'b0;
      held              = 1'b0;
      if (!scan.no_key && scan.found) begin
         held           = 1'b1;
         tracked_key_in = scan.key_idx;
         hold_count_in  = count_next;
         if (count_next >= threshold_ff) begin
            case (cfg.qual_mode)
               MODE_SHORT: begin
                  if (!repeat_started_ff) begin
                     repeat_started_in = 1'b1;
                     long_armed_in     = 1'b0;
                     reported_key_in   = scan.key_idx;
                     reported_long_in  = 1'b0;
                     event_flag        = 1'b1;
                  end
               end
               MODE_REPEAT: begin
                  reported_key_in  = scan.key_idx;
                  reported_long_in = 1'b0;
                  threshold_in     = cfg.repeat_delay_count;
                  hold_count_in    = '0;
                  // Keys outside the repeat mask stay quiet after the first event
                  if (!(repeat_started_ff && !repeat_mask_ext[scan.key_idx])) begin
                     if (repeat_started_ff) threshold_in = cfg.debounce_count;
                     event_flag        = 1'b1;
                     repeat_started_in = 1'b1;
                  end
               end
               MODE_LONG: begin
                  long_armed_in   = 1'b1;
                  reported_key_in = scan.key_idx;
                  if (long_mask_ext[scan.key_idx] && count_next > cfg.long_press_count) begin
                     repeat_started_in = 1'b1;
                     reported_long_in  = 1'b1;
                     event_flag        = 1'b1;
                  end else begin
                     reported_long_in = 1'b0;
                  end
               end
               default: ;
            endcase
         end
      end else begin
         // Release reports the armed key; an unknown code just drops the press
         if (scan.no_key && long_armed_ff) event_flag = 1'b1;
         long_armed_in     = 1'b0;
         repeat_started_in = 1'b0;
         threshold_in      = cfg.debounce_count;
         hold_count_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tracked_key_ff    <= NO_KEY_INDEX;
         hold_count_ff     <= '0;
         threshold_ff      <= RST_DEBOUNCE;
         long_armed_ff     <= 1'b0;
         repeat_started_ff <= 1'b0;
         reported_key_ff   <= NO_KEY_INDEX;
         reported_long_ff  <= 1'b0;
      end else if (step) begin
         tracked_key_ff    <= tracked_key_in;
         hold_count_ff     <= hold_count_in;
         threshold_ff      <= threshold_in;
         long_armed_ff     <= long_armed_in;
         repeat_started_ff <= repeat_started_in;
         reported_key_ff   <= reported_key_in;
         reported_long_ff  <= reported_long_in;
      end
   end

   assign result.key_event = event_flag;
   assign result.event_key = reported_key_in;
   assign result.long_mark = reported_long_in;
   assign result.key_held  = held;

   a_unknown_clears: assert property (@(posedge clock) disable iff (reset)
      step && !scan.no_key && !scan.found |=>
         hold_count_ff == '0 && !long_armed_ff && !repeat_started_ff)
      else $error("unknown code did not clear the press state");

   a_release_needs_arm: assert property (@(posedge clock) disable iff (reset)
      step && scan.no_key && event_flag |-> long_armed_ff)
      else $error("release event without an armed long press");

   // A release may still report a press armed before the mode changed
   a_short_once: assert property (@(posedge clock) disable iff (reset)
      step && !scan.no_key && event_flag && cfg.qual_mode == MODE_SHORT
         |-> !repeat_started_ff)
      else $error("short mode raised a second event for one press");

   a_long_mark_mode: assert property (@(posedge clock) disable iff (reset)
      step && event_flag && result.long_mark && !scan.no_key |-> cfg.qual_mode == MODE_LONG)
      else $error("long mark set on a fresh event outside long mode");

endmodule

@@ src/key_press_qualifier_unit.sv @@
// Top level of the key press qualifier: input register, qualifier core, result register.
// Each scan transaction gives exactly one result. The block takes one transaction per
// clock while the input side is not stalled, and holds each one first in the input
// register (where the key code is already matched to an index) and then in the result
// register, which is loaded in the same cycle that the hold counter and key state update.
// A waiting result stalls the input side only while the result register is still full
// and not being taken. Configuration writes take effect on the next clock and are meant
// to be made while no transaction is in flight. Reset needs no clearing pass.
module key_press_qualifier_unit #(
   parameter int KEY_COUNT = kpq_pkg::KEY_COUNT_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_no_key,
   input  logic [kpq_pkg::KEY_CODE_W-1:0]  req_raw_code,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_key_event,
   output logic [kpq_pkg::KEY_IDX_W-1:0]   rsp_event_key,
   output logic                            rsp_long_mark,
   output logic                            rsp_key_held,
   input  logic                            csr_write_en,
   input  logic [kpq_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [kpq_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import kpq_pkg::*;

   kpq_cfg_type    cfg;
   kpq_scan_type   scan_in, scan_ff;
   kpq_result_type result, result_ff;
   logic           scan_valid_ff, scan_valid_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           advance;
   logic           found;
   logic [KEY_IDX_W-1:0] key_idx;

   kpq_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   kpq_decode #(.KEY_COUNT(KEY_COUNT)) u_decode (
      .raw_code (req_raw_code),
      .found    (found),
      .key_idx  (key_idx)
   );

   assign scan_in = '{no_key: req_no_key, found: found, key_idx: key_idx};

   // Move the held transaction into the result register when that slot is free or being emptied
   assign advance   = scan_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !scan_valid_ff || advance;

   assign scan_valid_in = (req_valid && req_ready) || (scan_valid_ff && !advance);
   assign rsp_valid_in  = advance || (rsp_valid_ff && !rsp_ready);

   kpq_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .scan   (scan_ff),
      .cfg    (cfg),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         scan_valid_ff <= scan_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) scan_ff <= scan_in;
      if (advance) result_ff <= result;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_key_event = result_ff.key_event;
   assign rsp_event_key = result_ff.event_key;
   assign rsp_long_mark = result_ff.long_mark;
   assign rsp_key_held  = result_ff.key_held;

endmodule

@@ test/key_press_qualifier_unit_tb.sv @@
// Self-checking testbench for the key press qualifier: directed and random scan ticks.
`timescale 1ns / 100ps

module key_press_qualifier_unit_tb;
   import kpq_pkg::*;

   localparam int PIPE_LATENCY   = 4;
   localparam int WATCHDOG_LIMIT = 1000;

   logic                   clock        = 1'b0;
   logic                   reset        = 1'b1;
   logic                   req_valid    = 1'b0;
   logic                   req_ready;
   logic                   req_no_key   = 1'b1;
   logic [KEY_CODE_W-1:0]  req_raw_code = '1;
   logic                   rsp_valid;
   logic                   rsp_ready    = 1'b0;
   logic                   rsp_key_event;
   logic [KEY_IDX_W-1:0]   rsp_event_key;
   logic                   rsp_long_mark;
   logic                   rsp_key_held;
   logic                   csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index    = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata    = '0;

   key_press_qualifier_unit dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_no_key    (req_no_key),
      .req_raw_code  (req_raw_code),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_key_event (rsp_key_event),
      .rsp_event_key (rsp_event_key),
      .rsp_long_mark (rsp_long_mark),
      .rsp_key_held  (rsp_key_held),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Predicted key qualifier settings and state
   qual_mode_type        cfg_mode;
   logic [COUNT_W-1:0]   cfg_debounce;
   logic [COUNT_W-1:0]   cfg_repeat_delay;
   logic [COUNT_W-1:0]   cfg_long_press;
   logic [MASK_W-1:0]    cfg_repeat_mask;
   logic [MASK_W-1:0]    cfg_long_mask;
   logic [KEY_IDX_W-1:0] trk_key;
   logic [COUNT_W-1:0]   hold_cnt;
   logic [COUNT_W-1:0]   evt_threshold;
   logic                 long_armed;
   logic                 rpt_started;
   logic [KEY_IDX_W-1:0] rep_key;
   logic                 rep_long;

   kpq_result_type expected_results[$];

   bit send_idle = 1'b0;
   bit rsp_idle  = 1'b0;
   int long_stall_cycles = 0;
   int mismatches = 0;
   int scans_sent = 0;
   int results_checked = 0;
   int events_seen = 0;
   int settings_applied = 0;

   function automatic logic [KEY_CODE_W-1:0] scan_code_of(logic [KEY_IDX_W-1:0] k);
      return ~(8'h01 << k);
   endfunction

   function automatic logic [KEY_IDX_W-1:0] lookup_key(logic [KEY_CODE_W-1:0] code);
      for (int i = 0; i < 7; i++) begin
         if (code == scan_code_of(KEY_IDX_W'(i))) return KEY_IDX_W'(i);
      end
      return NO_KEY_INDEX;
   endfunction

   task automatic reset_model();
      cfg_mode         = MODE_LONG;
      cfg_debounce     = 8'd4;
      cfg_repeat_delay = 8'd40;
      cfg_long_press   = 8'd80;
      cfg_repeat_mask  = 7'd15;
      cfg_long_mask    = 7'd32;
      trk_key          = NO_KEY_INDEX;
      hold_cnt         = '0;
      evt_threshold    = 8'd4;
      long_armed       = 1'b0;
      rpt_started      = 1'b0;
      rep_key          = NO_KEY_INDEX;
      rep_long         = 1'b0;
   endtask

   // Advance the predicted state by one scan tick and return the expected result
   function automatic kpq_result_type predict_scan(logic nk, logic [KEY_CODE_W-1:0] code);
      kpq_result_type res;
      logic [KEY_IDX_W-1:0] k;
      logic fire;
      logic pressed;
      fire = 1'b0;
      pressed = 1'b0;
      if (!nk) begin
         k = lookup_key(code);
         if (k != NO_KEY_INDEX) begin
            pressed = 1'b1;
            if (k != trk_key) begin
               trk_key = k;
               hold_cnt = '0;
            end else begin
               hold_cnt = hold_cnt + 8'd1;
            end
            if (hold_cnt >= evt_threshold) begin
               case (cfg_mode)
                  MODE_SHORT: begin
                     if (!rpt_started) begin
                        rpt_started = 1'b1;
                        long_armed = 1'b0;
                        rep_key = k;
                        rep_long = 1'b0;
                        fire = 1'b1;
                     end
                  end
                  MODE_REPEAT: begin
                     rep_key = k;
                     rep_long = 1'b0;
                     evt_threshold = cfg_repeat_delay;
                     if (rpt_started && !cfg_repeat_mask[k]) begin
                        hold_cnt = '0;
                     end else begin
                        if (rpt_started) evt_threshold = cfg_debounce;
                        fire = 1'b1;
                        rpt_started = 1'b1;
                        hold_cnt = '0;
                     end
                  end
                  MODE_LONG: begin
                     long_armed = 1'b1;
                     rep_key = k;
                     if (cfg_long_mask[k] && hold_cnt > cfg_long_press) begin
                        rpt_started = 1'b1;
                        rep_long = 1'b1;
                        fire = 1'b1;
                     end else begin
                        rep_long = 1'b0;
                     end
                  end
                  default: ;
               endcase
            end
         end else begin
            // unknown code: drop flags, keep the tracked key
            long_armed = 1'b0;
            rpt_started = 1'b0;
            evt_threshold = cfg_debounce;
            hold_cnt = '0;
         end
      end else begin
         if (long_armed) begin
            long_armed = 1'b0;
            fire = 1'b1;
         end
         rpt_started = 1'b0;
         evt_threshold = cfg_debounce;
         hold_cnt = '0;
      end
      res.key_event = fire;
      res.event_key = rep_key;
      res.long_mark = rep_long;
      res.key_held  = pressed;
      return res;
   endfunction

   // Call at a rising edge; returns at the edge that accepts the transaction
   task automatic send_scan(logic nk, logic [KEY_CODE_W-1:0] code);
      int gap;
      gap = send_idle ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_no_key   <= nk;
      req_raw_code <= code;
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
      expected_results.push_back(predict_scan(nk, code));
      scans_sent++;
   endtask

   // Hold the input side until every expected result is back and the pipe is empty
   task automatic settle_pipeline();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (PIPE_LATENCY) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(posedge clock);
      case (idx)
         CSR_QUAL_MODE:    cfg_mode = qual_mode_type'(data[1:0]);
         CSR_DEBOUNCE:     cfg_debounce = data;
         CSR_REPEAT_DELAY: cfg_repeat_delay = data;
         CSR_LONG_PRESS:   cfg_long_press = data;
         CSR_REPEAT_MASK:  cfg_repeat_mask = data[MASK_W-1:0];
         CSR_LONG_MASK:    cfg_long_mask = data[MASK_W-1:0];
         default: ;
      endcase
   endtask

   task automatic apply_settings(qual_mode_type mode, logic [COUNT_W-1:0] deb,
                                 logic [COUNT_W-1:0] rdelay, logic [COUNT_W-1:0] lpress,
                                 logic [MASK_W-1:0] rmask, logic [MASK_W-1:0] lmask);
      settle_pipeline();
      write_csr(CSR_QUAL_MODE, {6'd0, mode});
      write_csr(CSR_DEBOUNCE, deb);
      write_csr(CSR_REPEAT_DELAY, rdelay);
      write_csr(CSR_LONG_PRESS, lpress);
      write_csr(CSR_REPEAT_MASK, {1'b0, rmask});
      write_csr(CSR_LONG_MASK, {1'b0, lmask});
      csr_write_en <= 1'b0;
      settings_applied++;
   endtask

   // Mostly well-formed presses with random keys and lengths, some noise in between
   task automatic run_key_sessions(int item_budget, bit with_long_hold);
      int sent;
      int hold_len;
      logic [KEY_IDX_W-1:0] k;
      sent = 0;
      if (with_long_hold) begin
         k = KEY_IDX_W'($urandom_range(0, 6));
         hold_len = $urandom_range(258, 270);
         repeat (hold_len) send_scan(1'b0, scan_code_of(k));
         send_scan(1'b1, 8'($urandom_range(0, 255)));
         sent = hold_len + 1;
      end
      while (sent < item_budget) begin
         if ($urandom_range(0, 9) < 2) begin
            send_scan(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            sent++;
         end else begin
            k = KEY_IDX_W'($urandom_range(0, 6));
            hold_len = $urandom_range(1, 12);
            for (int i = 0; i < hold_len; i++) begin
               if ($urandom_range(0, 11) == 0)
                  send_scan(1'b0, $urandom_range(0, 1) ? 8'hFF : 8'($urandom_range(0, 255)));
               else
                  send_scan(1'b0, scan_code_of(k));
               sent++;
            end
            // skip the release now and then so the next key follows directly
            if ($urandom_range(0, 3) != 0) begin
               repeat ($urandom_range(1, 3)) begin
                  send_scan(1'b1, 8'($urandom_range(0, 255)));
                  sent++;
               end
            end
         end
      end
   endtask

   task automatic test_directed_codes();
      send_idle = 1'b0;
      rsp_idle  = 1'b0;
      for (int k = 0; k < 7; k++) send_scan(1'b0, scan_code_of(KEY_IDX_W'(k)));
      send_scan(1'b0, 8'h00);
      send_scan(1'b0, 8'h7F);
      send_scan(1'b0, 8'hFF);
      // arm a press with reset settings, then release it for the held key's event
      repeat (5) send_scan(1'b0, scan_code_of(5));
      send_scan(1'b1, 8'hFE);
   endtask

   task automatic test_directed_modes();
      apply_settings(MODE_SHORT, 8'd0, 8'd0, 8'd0, 7'h7F, 7'h7F);
      repeat (2) send_scan(1'b0, scan_code_of(0));
      send_scan(1'b1, 8'h00);
      apply_settings(MODE_REPEAT, 8'd0, 8'd1, 8'd255, 7'h01, 7'h00);
      repeat (3) send_scan(1'b0, scan_code_of(0));
      repeat (3) send_scan(1'b0, scan_code_of(1));
      apply_settings(MODE_LONG, 8'd0, 8'd255, 8'd0, 7'h00, 7'h7F);
      repeat (3) send_scan(1'b0, scan_code_of(2));
      send_scan(1'b1, 8'hFF);
      apply_settings(MODE_NONE, 8'd255, 8'd255, 8'd255, 7'h7F, 7'h00);
      repeat (2) send_scan(1'b0, scan_code_of(3));
   endtask

   task automatic test_random_settings();
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: apply_settings(MODE_SHORT, 8'd3, 8'd40, 8'd80, 7'h0F, 7'h20);
            1: apply_settings(MODE_REPEAT, 8'd2, 8'd5, 8'd0, 7'h55, 7'h00);
            2: apply_settings(MODE_REPEAT, 8'd0, 8'd0, 8'd255, 7'h7F, 7'h7F);
            3: apply_settings(MODE_LONG, 8'd1, 8'd255, 8'd4, 7'h0F, 7'h7F);
            4: apply_settings(MODE_LONG, 8'd255, 8'd8, 8'd255, 7'h00, 7'h2A);
            5: apply_settings(MODE_NONE, 8'd2, 8'd3, 8'd3, 7'h7F, 7'h7F);
            6: apply_settings(qual_mode_type'($urandom_range(0, 3)),
                              COUNT_W'($urandom_range(0, 6)),
                              COUNT_W'($urandom_range(0, 10)),
                              COUNT_W'($urandom_range(0, 10)),
                              MASK_W'($urandom_range(0, 127)),
                              MASK_W'($urandom_range(0, 127)));
            default: apply_settings(qual_mode_type'($urandom_range(0, 3)),
                                    COUNT_W'($urandom_range(0, 255)),
                                    COUNT_W'($urandom_range(0, 255)),
                                    COUNT_W'($urandom_range(0, 255)),
                                    MASK_W'($urandom_range(0, 127)),
                                    MASK_W'($urandom_range(0, 127)));
         endcase
         send_idle = (phase % 3) != 0;
         rsp_idle  = (phase % 3) != 1;
         // debounce 255 needs a hold long enough to arm and wrap the counter
         run_key_sessions(phase == 4 ? 280 : 62, phase == 4);
      end
   endtask

   task automatic test_backpressure();
      apply_settings(MODE_REPEAT, 8'd1, 8'd2, 8'd0, 7'h7F, 7'h00);
      send_idle = 1'b0;
      rsp_idle  = 1'b1;
      long_stall_cycles = 48;
      run_key_sessions(30, 1'b0);
      settle_pipeline();
      long_stall_cycles = 30;
      run_key_sessions(20, 1'b0);
   endtask

   task automatic compare_field(string field, int want, int got);
      if (want != got) begin
         mismatches++;
         $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
      end
   endtask

   initial begin : result_checker
      kpq_result_type want;
      forever begin
         @(negedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               mismatches++;
               $display("%0t: result expected none actual event %0d key %0d long %0d held %0d",
                        $time, rsp_key_event, rsp_event_key, rsp_long_mark, rsp_key_held);
            end else begin
               want = expected_results.pop_front();
               compare_field("key_event", int'(want.key_event), int'(rsp_key_event));
               compare_field("event_key", int'(want.event_key), int'(rsp_event_key));
               compare_field("long_mark", int'(want.long_mark), int'(rsp_long_mark));
               compare_field("key_held", int'(want.key_held), int'(rsp_key_held));
               results_checked++;
               if (want.key_event) events_seen++;
            end
         end
      end
   end

   initial begin : response_sink
      int pause;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (long_stall_cycles > 0) begin
            pause = long_stall_cycles;
            long_stall_cycles = 0;
            rsp_ready <= 1'b0;
            repeat (pause) @(posedge clock);
         end else begin
            pause = rsp_idle ? $urandom_range(0, 5) : 0;
            if (pause > 0) begin
               rsp_ready <= 1'b0;
               repeat (pause) @(posedge clock);
            end
         end
         rsp_ready <= 1'b1;
         do @(negedge clock); while (!rsp_valid && long_stall_cycles == 0);
         @(posedge clock);
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(negedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("%0t: no transaction for %0d cycles", $time, quiet);
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      reset_model();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed_codes();
      test_directed_modes();
      test_random_settings();
      test_backpressure();
      settle_pipeline();
      $display("Sent %0d scan ticks under %0d settings in all four modes", scans_sent,
               settings_applied);
      $display("Checked %0d results, %0d of them key events, %0d mismatches",
               results_checked, events_seen, mismatches);
      if (mismatches == 0 && expected_results.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

@@ filelist.f @@
src/kpq_pkg.sv
src/kpq_decode.sv
src/kpq_csr.sv
src/kpq_core.sv
src/key_press_qualifier_unit.sv
test/key_press_qualifier_unit_tb.sv
